@@ rtl/knm_pkg.sv @@
`timescale 1ns / 1ps
// knm_pkg: shared constants, state encoding and interface structs of the knapsack solver
// no dependencies
package knm_pkg;

   localparam int MAX_CAPACITY = 1023;
   localparam int DEPTH        = MAX_CAPACITY + 1;
   localparam int ADDR_W       = $clog2(DEPTH);
   localparam int WEIGHT_W     = 10;
   localparam int VALUE_W      = 16;
   localparam int CAP_W        = 10;
   localparam int BEST_W       = 32;
   localparam int CMP_W        = (ADDR_W > WEIGHT_W) ? ADDR_W + 1 : WEIGHT_W + 1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_PUSH
   } state_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [BEST_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic              push;
      logic [BEST_W-1:0] value;
   } result_type;

endpackage

@@ rtl/knapsack_max_value.sv @@
`timescale 1ns / 1ps
// knapsack_max_value: top level of the 0/1 knapsack solver, csr register and result register
// uses knm_pkg, knm_row_ram, knm_sweep_ctrl
//
//  channel   direction  transaction            payload
//  req_      in         one item               tdata[9:0] weight, tdata[25:10] value, tlast last
//  rsp_      out        one answer per problem tdata[31:0] best value
//  csr_      in         capacity write         csr_data[9:0] capacity
//
// an item takes a sweep (one read-modify-write of the row memory per capacity),
// a drain state and an accept in the idle state
// the last item of a problem adds a result hand-off state and a clearing pass of the whole row
// reset starts the same clearing pass; req_tready stays low until it ends
// a stalled rsp_ holds its transaction; the block waits after the last sweep until it is free
module knapsack_max_value (
   input  logic        clock,
   input  logic        reset,
   // configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [9:0]  csr_data,      // [9:0] capacity
   // item stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,     // [9:0] item_weight, [25:10] item_value, [31:26] zero
   input  logic        req_tlast,     // last_item
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata      // [31:0] best_value
);

   logic [knm_pkg::CAP_W-1:0]  cap_ff, cap_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [knm_pkg::BEST_W-1:0] rsp_data_ff, rsp_data_in;

   knm_pkg::result_type        result;
   knm_pkg::ram_wr_type        ram_wr;
   logic [knm_pkg::ADDR_W-1:0] rd_a_addr, rd_b_addr;
   logic [knm_pkg::BEST_W-1:0] rd_a_data, rd_b_data;
   logic                       result_free;

   // capacity register, always writable
   assign csr_ready = 1'b1;
   assign cap_in    = (csr_valid && csr_ready) ? csr_data : cap_ff;

   // output register frees when empty or when its transaction completes
   assign result_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (result.push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   knm_sweep_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .capacity    (cap_ff),
      .item_valid  (req_tvalid),
      .item_ready  (req_tready),
      .item_weight (req_tdata[9:0]),
      .item_value  (req_tdata[25:10]),
      .last_item   (req_tlast),
      .result_free (result_free),
      .result      (result),
      .ram_wr      (ram_wr),
      .rd_a_addr   (rd_a_addr),
      .rd_b_addr   (rd_b_addr),
      .rd_a_data   (rd_a_data),
      .rd_b_data   (rd_b_data)
   );

   // best value per capacity, one row
   knm_row_ram #(
      .DEPTH  (knm_pkg::DEPTH),
      .ADDR_W (knm_pkg::ADDR_W),
      .DATA_W (knm_pkg::BEST_W)
   ) u_row (
      .clock     (clock),
      .wr        (ram_wr),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

endmodule

@@ rtl/knm_row_ram.sv @@
`timescale 1ns / 1ps
// knm_row_ram: one write port, two registered read ports, holds the best-value row
// uses knm_pkg for the write request struct
module knm_row_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10,
   parameter int DATA_W = 32
) (
   input  logic                clock,
   input  knm_pkg::ram_wr_type wr,
   input  logic [ADDR_W-1:0]   rd_a_addr,
   input  logic [ADDR_W-1:0]   rd_b_addr,
   output logic [DATA_W-1:0]   rd_a_data,
   output logic [DATA_W-1:0]   rd_b_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule

@@ rtl/knm_sweep_ctrl.sv @@
`timescale 1ns / 1ps
// knm_sweep_ctrl: sequencer for the per-item capacity sweep, the clearing pass and result hand-off
// uses knm_pkg; drives the row ram ports of knm_row_ram
module knm_sweep_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [knm_pkg::CAP_W-1:0]       capacity,
   input  logic                            item_valid,
   output logic                            item_ready,
   input  logic [knm_pkg::WEIGHT_W-1:0]    item_weight,
   input  logic [knm_pkg::VALUE_W-1:0]     item_value,
   input  logic                            last_item,
   input  logic                            result_free,
   output knm_pkg::result_type             result,
   output knm_pkg::ram_wr_type             ram_wr,
   output logic [knm_pkg::ADDR_W-1:0]      rd_a_addr,
   output logic [knm_pkg::ADDR_W-1:0]      rd_b_addr,
   input  logic [knm_pkg::BEST_W-1:0]      rd_a_data,
   input  logic [knm_pkg::BEST_W-1:0]      rd_b_data
);

   localparam logic [knm_pkg::ADDR_W-1:0] TOP_ADDR = knm_pkg::ADDR_W'(knm_pkg::MAX_CAPACITY);

   knm_pkg::state_type state_ff, state_in;
   logic [knm_pkg::ADDR_W-1:0]   w_ff, w_in;
   logic [knm_pkg::WEIGHT_W-1:0] wt_ff, wt_in;
   logic [knm_pkg::VALUE_W-1:0]  val_ff, val_in;
   logic                         last_ff, last_in;
   logic                         s1_valid_ff, s1_valid_in;
   logic                         s1_take_ff, s1_take_in;
   logic [knm_pkg::ADDR_W-1:0]   s1_addr_ff, s1_addr_in;
   logic [knm_pkg::BEST_W-1:0]   best_ff, best_in;

   logic [knm_pkg::ADDR_W-1:0]   cap_eff;
   logic [knm_pkg::BEST_W:0]     sum;
   logic [knm_pkg::BEST_W-1:0]   cand;
   logic                         improve;
   logic [knm_pkg::BEST_W-1:0]   new_val;
   logic                         accept;

   // answer index, limited to the top of the row
   assign cap_eff = (knm_pkg::CMP_W'(capacity) > knm_pkg::CMP_W'(knm_pkg::MAX_CAPACITY))
                    ? TOP_ADDR : knm_pkg::ADDR_W'(capacity);

   // stage 1: saturating candidate against the old entry
   assign sum     = {1'b0, rd_b_data} + (knm_pkg::BEST_W + 1)'(val_ff);
   assign cand    = sum[knm_pkg::BEST_W] ? '1 : sum[knm_pkg::BEST_W-1:0];
   assign improve = s1_valid_ff && s1_take_ff && (cand > rd_a_data);
   assign new_val = improve ? cand : rd_a_data;

   assign accept  = item_valid && item_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         knm_pkg::ST_CLEAR: begin
            if (w_ff == '0) state_in = knm_pkg::ST_IDLE;
         end
         knm_pkg::ST_IDLE: begin
            if (accept) state_in = knm_pkg::ST_SWEEP;
         end
         knm_pkg::ST_SWEEP: begin
            if (w_ff == '0) state_in = knm_pkg::ST_DRAIN;
         end
         knm_pkg::ST_DRAIN: begin
            state_in = last_ff ? knm_pkg::ST_PUSH : knm_pkg::ST_IDLE;
         end
         knm_pkg::ST_PUSH: begin
            if (result_free) state_in = knm_pkg::ST_CLEAR;
         end
         default: state_in = knm_pkg::ST_CLEAR;
      endcase
   end

   // outputs and datapath
   always_comb begin
      item_ready   = 1'b0;
      w_in         = w_ff;
      wt_in        = wt_ff;
      val_in       = val_ff;
      last_in      = last_ff;
      s1_valid_in  = 1'b0;
      s1_take_in   = 1'b0;
      s1_addr_in   = w_ff;
      best_in      = best_ff;
      rd_a_addr    = w_ff;
      rd_b_addr    = knm_pkg::ADDR_W'(knm_pkg::CMP_W'(w_ff) - knm_pkg::CMP_W'(wt_ff));
      ram_wr.en    = improve;
      ram_wr.addr  = s1_addr_ff;
      ram_wr.data  = cand;
      result.push  = 1'b0;
      result.value = best_ff;

      if (s1_valid_ff && (s1_addr_ff == cap_eff)) best_in = new_val;

      case (state_ff)
         knm_pkg::ST_CLEAR: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = w_ff;
            ram_wr.data = '0;
            w_in        = w_ff - knm_pkg::ADDR_W'(1);
         end
         knm_pkg::ST_IDLE: begin
            item_ready = 1'b1;
            if (accept) begin
               wt_in   = item_weight;
               val_in  = item_value;
               last_in = last_item;
               w_in    = TOP_ADDR;
            end
         end
         knm_pkg::ST_SWEEP: begin
            s1_valid_in = 1'b1;
            s1_take_in  = knm_pkg::CMP_W'(wt_ff) <= knm_pkg::CMP_W'(w_ff);
            w_in        = w_ff - knm_pkg::ADDR_W'(1);
         end
         knm_pkg::ST_DRAIN: begin
         end
         knm_pkg::ST_PUSH: begin
            result.push = result_free;
            w_in        = TOP_ADDR;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= knm_pkg::ST_CLEAR;
         w_ff        <= TOP_ADDR;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         w_ff        <= w_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wt_ff      <= wt_in;
      val_ff     <= val_in;
      last_ff    <= last_in;
      s1_take_ff <= s1_take_in;
      s1_addr_ff <= s1_addr_in;
      best_ff    <= best_in;
   end

endmodule

@@ rtl/knm_checker.sv @@
`timescale 1ns / 1ps
// knm_checker: port-level assertions for knapsack_max_value, bound to the top level
// no package dependency
module knm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // clearing pass follows reset
   a_reset_blocks: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("req_tready high right after reset");

   // one item at a time: the sweep starts at once
   a_item_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("req_tready high right after an accepted item");

   // a new answer appears only while no item can be taken
   a_rsp_when_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !req_tready)
      else $error("answer raised while the block accepts items");

   // stalled answer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled answer changed");

endmodule

bind knapsack_max_value knm_checker u_knm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking bench for knapsack_max_value, with directed and random problems
// depends on knm_pkg and the knapsack_max_value rtl
module tb_top;

   localparam int SETTLE_CYCLES = 2200;   // item sweep + result hand-off + clearing pass, padded

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [9:0]  csr_data   = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   knapsack_max_value dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),      // [9:0] capacity
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),     // [9:0] item_weight, [25:10] item_value, [31:26] zero
      .req_tlast  (req_tlast),     // last_item
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)      // [31:0] best_value
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow copy of the solver: one row of best values and the capacity register
   logic [knm_pkg::BEST_W-1:0] best_row [0:knm_pkg::MAX_CAPACITY];
   logic [knm_pkg::CAP_W-1:0]  capacity_shadow = '0;
   logic [knm_pkg::BEST_W-1:0] pending_answers [$];
   int                         mismatch_count = 0;

   // idling knobs, percent of cycles
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   // long receiver hold-off, handed to the ready process
   int hold_request  = 0;
   int hold_left     = 0;

   initial begin
      foreach (best_row[i]) best_row[i] = '0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch: %s got 0x%08h want 0x%08h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   function automatic logic [knm_pkg::BEST_W-1:0] add_saturating(
         input logic [knm_pkg::BEST_W-1:0] a, input logic [knm_pkg::VALUE_W-1:0] b);
      logic [knm_pkg::BEST_W:0] sum;
      sum = {1'b0, a} + (knm_pkg::BEST_W + 1)'(b);
      return sum[knm_pkg::BEST_W] ? {knm_pkg::BEST_W{1'b1}} : sum[knm_pkg::BEST_W-1:0];
   endfunction

   // one item of the dynamic program: sweep capacities high to low so each item is used once
   task automatic solve_item(input logic [knm_pkg::WEIGHT_W-1:0] weight,
                             input logic [knm_pkg::VALUE_W-1:0] value, input logic last);
      logic [knm_pkg::BEST_W-1:0] cand;
      int                         answer_at;
      for (int w = knm_pkg::MAX_CAPACITY; w >= 0; w--) begin
         if (int'(weight) <= w) begin
            cand = add_saturating(best_row[w - int'(weight)], value);
            if (cand > best_row[w]) best_row[w] = cand;
         end
      end
      if (last) begin
         // capacity in force when the last item lands, clipped to the row length
         answer_at = (int'(capacity_shadow) > knm_pkg::MAX_CAPACITY) ? knm_pkg::MAX_CAPACITY
                                                                     : int'(capacity_shadow);
         pending_answers.push_back(best_row[answer_at]);
         foreach (best_row[i]) best_row[i] = '0;
      end
   endtask

   // offer one item, with random gaps, and fold it into the shadow row once accepted
   task automatic send_item(input logic [knm_pkg::WEIGHT_W-1:0] weight,
                            input logic [knm_pkg::VALUE_W-1:0] value, input logic last);
      int gap;
      gap = 0;
      // an occasional long gap lets the next item land on any phase of the sweep
      if (send_idle_pct > 0 && $urandom_range(0, 15) == 0) gap = $urandom_range(1, 1100);
      while (gap > 0 || $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         if (gap > 0) gap--;
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, value, weight};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      solve_item(weight, value, last);
   endtask

   // drop valid, wait for every answer, then let the clearing pass run out
   task automatic wait_block_idle();
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [knm_pkg::CAP_W-1:0] cap);
      csr_valid <= 1'b1;
      csr_data  <= cap;
      do @(posedge clock); while (!csr_ready);
      capacity_shadow = cap;
      csr_valid <= 1'b0;
   endtask

   // receiver side: random stalls, or a counted hold-off when one is requested
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // answer checker: every accepted transaction against the oldest expected answer
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("unexpected best_value", rsp_tdata, '0);
         end else begin
            if (rsp_tdata !== pending_answers[0])
               report_mismatch("best_value", rsp_tdata, pending_answers[0]);
            void'(pending_answers.pop_front());
         end
      end
   end

   // capacity stays at its reset value of zero; a zero-weight item is still taken
   task automatic test_reset_capacity();
      send_item(10'd0, 16'd100, 1'b1);
      send_item(10'd1, 16'd500, 1'b0);
      send_item(10'd0, 16'd7, 1'b1);
      wait_block_idle();
   endtask

   // field extremes: full capacity, heaviest items, largest and smallest values
   task automatic test_extremes();
      write_capacity(10'd1023);
      send_item(10'd1023, 16'hFFFF, 1'b0);
      send_item(10'd1023, 16'd1, 1'b0);
      send_item(10'd512, 16'hFFFF, 1'b0);
      send_item(10'd511, 16'hFFFE, 1'b0);
      send_item(10'd0, 16'd0, 1'b1);
      wait_block_idle();
      write_capacity(10'd10);
      send_item(10'd11, 16'd500, 1'b0);   // too heavy for the answer capacity
      send_item(10'd10, 16'd7, 1'b0);
      send_item(10'd5, 16'd4, 1'b0);
      send_item(10'd5, 16'd4, 1'b1);
      wait_block_idle();
      write_capacity(10'd0);
      send_item(10'd1, 16'hFFFF, 1'b0);
      send_item(10'd1023, 16'hFFFF, 1'b1);
      wait_block_idle();
   endtask

   // zero-weight items pile up at every capacity, including capacity zero
   task automatic test_zero_weight();
      write_capacity(10'd3);
      send_item(10'd0, 16'hFFFF, 1'b0);
      send_item(10'd0, 16'hFFFF, 1'b0);
      send_item(10'd3, 16'd9, 1'b1);
      wait_block_idle();
   endtask

   // capacity rewritten between items of one problem: the answer uses the new one
   task automatic test_capacity_change();
      write_capacity(10'd20);
      send_item(10'd15, 16'd30, 1'b0);
      send_item(10'd5, 16'd10, 1'b0);
      wait_block_idle();
      write_capacity(10'd5);
      send_item(10'd30, 16'd1, 1'b1);
      wait_block_idle();
   endtask

   // receiver holds off long enough that a pending answer blocks new items
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      write_capacity(10'd40);
      hold_request = 6000;
      send_item(10'd12, 16'd300, 1'b0);
      send_item(10'd30, 16'd700, 1'b1);
      send_item(10'd8, 16'd50, 1'b0);
      send_item(10'd33, 16'd900, 1'b1);
      send_item(10'd40, 16'd1000, 1'b0);
      send_item(10'd1, 16'd2, 1'b1);
      wait_block_idle();
   endtask

   function automatic logic [knm_pkg::CAP_W-1:0] pick_capacity();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 10'd1023;
         2, 3:    return knm_pkg::CAP_W'($urandom_range(1, 63));
         default: return knm_pkg::CAP_W'($urandom_range(0, 1023));
      endcase
   endfunction

   function automatic logic [knm_pkg::WEIGHT_W-1:0] pick_weight();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return knm_pkg::WEIGHT_W'($urandom_range(0, 1023));
         // mostly weights that compete for the configured capacity
         default: return knm_pkg::WEIGHT_W'($urandom_range(0,
                            (capacity_shadow == 0) ? 15 : int'(capacity_shadow)));
      endcase
   endfunction

   function automatic logic [knm_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 16'hFFFF;
         1:       return '0;
         default: return knm_pkg::VALUE_W'($urandom);
      endcase
   endfunction

   // whole random problems, capacity rewritten now and then between problems
   task automatic test_random(input int item_goal, input int idle_pct, input int stall_pct);
      int sent;
      int len;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      wait_block_idle();
      write_capacity(pick_capacity());
      while (sent < item_goal) begin
         if ($urandom_range(0, 3) == 0) begin
            wait_block_idle();
            write_capacity(pick_capacity());
         end
         len = $urandom_range(1, 6);
         for (int k = 0; k < len; k++)
            send_item(pick_weight(), pick_value(), k == len - 1);
         sent += len;
      end
      wait_block_idle();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_capacity();
      test_extremes();
      test_zero_weight();
      test_capacity_change();
      test_backpressure();
      test_random(136, 0, 0);
      test_random(136, 79, 0);
      test_random(136, 0, 79);
      test_random(136, 19, 19);
      foreach (pending_answers[i]) report_mismatch("missing best_value", '0, pending_answers[i]);
      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("knapsack_max_value verification clean");
      end else begin
         $display("knapsack_max_value verification failed");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #200_000_000;
      $display("knapsack_max_value verification failed");
      $finish;
   end

endmodule
